[rtl/core/critically_damped_smoother_unit_macros.svh]
// assertion macros shared by the smoother rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef CRITICALLY_DAMPED_SMOOTHER_UNIT_MACROS_SVH
`define CRITICALLY_DAMPED_SMOOTHER_UNIT_MACROS_SVH

// same-cycle implication
`define CDS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smoother assertion failed");

// next-cycle implication
`define CDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smoother assertion failed");

// condition that must never hold
`define CDS_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("smoother assertion failed");

`endif

[rtl/core/cds_pkg.sv]
// types, constants and saturation helpers for the smoother
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package cds_pkg;

    // working width of intermediate values, holds +-2^48 with margin
    localparam int VW = 50;
    typedef logic signed [VW-1:0] val_t;

    localparam logic signed [VW:0] ISAT_W  = 51'sd281474976710656;
    localparam logic signed [VW:0] NISAT_W = -51'sd281474976710656;
    localparam logic [VW-1:0]      ISAT    = 50'd281474976710656;

    localparam logic [30:0] MIN_DT  = 31'd66;
    localparam logic [30:0] MIN_ST  = 31'd7;
    localparam val_t        C048    = 50'sd31457;
    localparam val_t        C0235   = 50'sd15401;
    localparam val_t        X_LIM_V = 50'sd8388608;
    localparam logic [23:0] X_LIMIT = 24'h80_0000;
    localparam logic [37:0] ONE_Q   = 38'd65536;

    // divider widths and numerators
    localparam int DNW = 34;
    localparam int DDW = 38;
    localparam logic [DNW-1:0] NUM_OMEGA = 34'h2_0000_0000;
    localparam logic [DNW-1:0] NUM_FAC   = 34'h1_0000_0000;

    // multiplier operand widths, b is taken in two digits
    localparam int MAW = 49;
    localparam int MBW = 34;
    localparam int DGW = MBW / 2;

    typedef enum logic [4:0] {
        CS_IDLE,
        CS_OMEGA,
        CS_X,
        CS_X2,
        CS_X3,
        CS_C48,
        CS_C235,
        CS_DEN,
        CS_FAC,
        CS_MAXC,
        CS_CLAMP,
        CS_OC,
        CS_TEMP,
        CS_OT,
        CS_NV,
        CS_RES,
        CS_FIN
    } ctl_state_t;

    typedef enum logic [2:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_ADD,
        MP_DONE
    } mul_ph_t;

    typedef struct packed {
        ctl_state_t op;
        logic       start;
        logic       load;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic short_in;
    } sts_t;

    function automatic val_t isat(input logic signed [VW:0] v);
        if (v > ISAT_W) begin
            return ISAT_W[VW-1:0];
        end
        if (v < NISAT_W) begin
            return NISAT_W[VW-1:0];
        end
        return v[VW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input val_t v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

[rtl/core/critically_damped_smoother_unit.sv]
// Critically damped smoother, top level: one beat in gives one beat out with the
// new position and velocity in signed q16.16. A beat runs two restoring divisions
// of 34 quotient bits, for omega and the decay factor, plus eleven products on one
// shared 49x17-bit multiplier. A beat with a time step under 0.001 s skips these
// and goes straight from accept to the finish step. A new beat is taken once the
// sequencer is back in idle, even while the last result still waits.
// Depends on cds_pkg, cds_ctrl, cds_datapath and the macros header.
`timescale 1ns / 1ps
`include "critically_damped_smoother_unit_macros.svh"

module critically_damped_smoother_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] current_pos,
    input  logic signed [31:0] goal_pos,
    input  logic [30:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_pos,
    output logic signed [31:0] new_velocity,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [30:0]   smooth_time_reg, max_speed_reg;
    logic          cfg_wr;
    cds_pkg::cmd_t cmd;
    cds_pkg::sts_t sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {1'b0, max_speed_reg} : {1'b0, smooth_time_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            smooth_time_reg <= 31'd65536;
            max_speed_reg   <= 31'h7FFF_FFFF;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                max_speed_reg <= pwdata[30:0];
            end else begin
                smooth_time_reg <= pwdata[30:0];
            end
        end
    end

    cds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cds_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .current_pos  (current_pos),
        .goal_pos     (goal_pos),
        .time_step    (time_step),
        .smooth_time  (smooth_time_reg),
        .max_speed    (max_speed_reg),
        .new_pos      (new_pos),
        .new_velocity (new_velocity)
    );

    `CDS_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall)
    `CDS_ASSERT_IMPL(a_finish_slot_free, cmd.finish, !out_valid || !out_stall)
    `CDS_ASSERT_NEVER(a_one_unit_done, sts.mul_done && sts.div_done)

endmodule

[rtl/core/cds_mul.sv]
// sign-magnitude q16.16 multiplier, 49 x 34 bits over two 17-bit digits
// depends on cds_pkg
`timescale 1ns / 1ps

module cds_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  cds_pkg::val_t  a,
    input  cds_pkg::val_t  b,
    output logic           done,
    output cds_pkg::val_t  p
);

    localparam int PPW = cds_pkg::MAW + cds_pkg::DGW;
    localparam int PW  = cds_pkg::MAW + cds_pkg::MBW;

    cds_pkg::mul_ph_t ph_reg, ph_next;
    logic                    neg_reg;
    logic [cds_pkg::MAW-1:0] ma_reg;
    logic [cds_pkg::MBW-1:0] mb_reg;
    logic [PPW-1:0]          pp_reg;
    logic [PW-1:0]           acc_reg;

    cds_pkg::val_t   a_abs, b_abs, mag;
    logic [PW-17:0]  sh;

    assign a_abs = a[cds_pkg::VW-1] ? -a : a;
    assign b_abs = b[cds_pkg::VW-1] ? -b : b;

    always_comb
    begin
        unique case (ph_reg)
            cds_pkg::MP_IDLE: ph_next = start ? cds_pkg::MP_LO : cds_pkg::MP_IDLE;
            cds_pkg::MP_LO:   ph_next = cds_pkg::MP_HI;
            cds_pkg::MP_HI:   ph_next = cds_pkg::MP_ADD;
            cds_pkg::MP_ADD:  ph_next = cds_pkg::MP_DONE;
            default:          ph_next = cds_pkg::MP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ph_reg <= cds_pkg::MP_IDLE;
        end else begin
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_reg == cds_pkg::MP_IDLE && start) begin
            ma_reg  <= a_abs[cds_pkg::MAW-1:0];
            mb_reg  <= b_abs[cds_pkg::MBW-1:0];
            neg_reg <= a[cds_pkg::VW-1] ^ b[cds_pkg::VW-1];
        end
        if (ph_reg == cds_pkg::MP_LO) begin
            pp_reg <= {{cds_pkg::DGW{1'b0}}, ma_reg}
                    * {{cds_pkg::MAW{1'b0}}, mb_reg[cds_pkg::DGW-1:0]};
        end
        if (ph_reg == cds_pkg::MP_HI) begin
            acc_reg <= {{(PW-PPW){1'b0}}, pp_reg};
            pp_reg  <= {{cds_pkg::DGW{1'b0}}, ma_reg}
                     * {{cds_pkg::MAW{1'b0}}, mb_reg[cds_pkg::MBW-1:cds_pkg::DGW]};
        end
        if (ph_reg == cds_pkg::MP_ADD) begin
            // high digit lands one digit up
            acc_reg <= acc_reg + {pp_reg, {cds_pkg::DGW{1'b0}}};
        end
    end

    // drop 16 fraction bits, clip magnitude at 2^48
    assign sh  = acc_reg[PW-1:16];
    assign mag = (sh > {{(PW-16-cds_pkg::VW){1'b0}}, cds_pkg::ISAT})
               ? cds_pkg::ISAT : sh[cds_pkg::VW-1:0];
    assign p    = neg_reg ? -mag : mag;
    assign done = (ph_reg == cds_pkg::MP_DONE);

endmodule

[rtl/core/cds_div.sv]
// restoring unsigned divider, one quotient bit per cycle
// depends on cds_pkg
`timescale 1ns / 1ps

module cds_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [cds_pkg::DNW-1:0] num,
    input  logic [cds_pkg::DDW-1:0] den,
    output logic                    done,
    output logic [cds_pkg::DNW-1:0] quo
);

    localparam int CW = $clog2(cds_pkg::DNW + 1);

    logic                    busy_reg, done_reg;
    logic [CW-1:0]           cnt_reg;
    logic [cds_pkg::DDW-1:0] rem_reg, den_reg;
    logic [cds_pkg::DNW-1:0] q_reg;

    logic [cds_pkg::DDW:0]   trial;
    logic [cds_pkg::DDW:0]   sub;
    logic                    ge;

    assign trial = {rem_reg, q_reg[cds_pkg::DNW-1]};
    assign sub   = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(cds_pkg::DNW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg) begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? sub[cds_pkg::DDW-1:0] : trial[cds_pkg::DDW-1:0];
            q_reg   <= {q_reg[cds_pkg::DNW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

[rtl/core/cds_datapath.sv]
// smoother datapath: operand registers, shared multiplier and divider, result registers
// depends on cds_pkg, cds_mul, cds_div
`timescale 1ns / 1ps

module cds_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cds_pkg::cmd_t       cmd,
    output cds_pkg::sts_t       sts,
    input  logic signed [31:0]  current_pos,
    input  logic signed [31:0]  goal_pos,
    input  logic [30:0]         time_step,
    input  logic [30:0]         smooth_time,
    input  logic [30:0]         max_speed,
    output logic signed [31:0]  new_pos,
    output logic signed [31:0]  new_velocity
);

    logic signed [31:0] cur_reg, goal_reg, vel_reg, new_pos_reg, new_vel_reg;
    logic [30:0]        dt_reg, st_reg, omega_reg;
    logic               short_reg;
    logic [23:0]        x_reg;
    logic [37:0]        den_reg;
    logic [16:0]        fac_reg;
    cds_pkg::val_t      x2_reg, x3_reg, t48_reg, t235_reg, maxc_reg;
    cds_pkg::val_t      change_reg, t_reg, temp_reg, nv_reg, res_reg;

    cds_pkg::val_t      dt_v, omega_v, x_v, fac_v, st_v, ms_v, cur_v, goal_v, vel_v;
    cds_pkg::val_t      diff, gd, mul_a, mul_b, mul_p;
    logic signed [50:0] vel_pt, vel_mt, ch_pt, tgt, res_sum;
    logic               mul_start, div_start, mul_done, div_done, ovs;
    logic [cds_pkg::DNW-1:0] div_num, div_quo;
    logic [cds_pkg::DDW-1:0] div_den;

    assign dt_v    = {19'b0, dt_reg};
    assign omega_v = {19'b0, omega_reg};
    assign x_v     = {26'b0, x_reg};
    assign fac_v   = {33'b0, fac_reg};
    assign st_v    = {19'b0, st_reg};
    assign ms_v    = {19'b0, max_speed};
    assign cur_v   = {{18{cur_reg[31]}}, cur_reg};
    assign goal_v  = {{18{goal_reg[31]}}, goal_reg};
    assign vel_v   = {{18{vel_reg[31]}}, vel_reg};

    assign diff    = cur_v - goal_v;
    assign gd      = goal_v - cur_v;
    assign vel_pt  = {vel_v[49], vel_v} + {t_reg[49], t_reg};
    assign vel_mt  = {vel_v[49], vel_v} - {t_reg[49], t_reg};
    assign ch_pt   = {change_reg[49], change_reg} + {temp_reg[49], temp_reg};
    assign tgt     = {cur_v[49], cur_v} - {change_reg[49], change_reg};
    assign res_sum = tgt + {mul_p[49], mul_p};
    assign ovs     = ((gd > 0) == (res_reg > goal_v));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            cds_pkg::CS_X:    begin mul_a = dt_v;               mul_b = omega_v; end
            cds_pkg::CS_X2:   begin mul_a = x_v;                mul_b = x_v;     end
            cds_pkg::CS_X3:   begin mul_a = x2_reg;             mul_b = x_v;     end
            cds_pkg::CS_C48:  begin mul_a = x2_reg;             mul_b = cds_pkg::C048;  end
            cds_pkg::CS_C235: begin mul_a = x3_reg;             mul_b = cds_pkg::C0235; end
            cds_pkg::CS_MAXC: begin mul_a = ms_v;               mul_b = st_v;    end
            cds_pkg::CS_OC:   begin mul_a = change_reg;         mul_b = omega_v; end
            cds_pkg::CS_TEMP: begin mul_a = cds_pkg::isat(vel_pt); mul_b = dt_v; end
            cds_pkg::CS_OT:   begin mul_a = temp_reg;           mul_b = omega_v; end
            cds_pkg::CS_NV:   begin mul_a = cds_pkg::isat(vel_mt); mul_b = fac_v; end
            cds_pkg::CS_RES:  begin mul_a = cds_pkg::isat(ch_pt);  mul_b = fac_v; end
            default:          begin mul_a = '0;                 mul_b = '0;      end
        endcase
    end

    assign mul_start = cmd.start && (cmd.op == cds_pkg::CS_X || cmd.op == cds_pkg::CS_X2
                     || cmd.op == cds_pkg::CS_X3 || cmd.op == cds_pkg::CS_C48
                     || cmd.op == cds_pkg::CS_C235 || cmd.op == cds_pkg::CS_MAXC
                     || cmd.op == cds_pkg::CS_OC || cmd.op == cds_pkg::CS_TEMP
                     || cmd.op == cds_pkg::CS_OT || cmd.op == cds_pkg::CS_NV
                     || cmd.op == cds_pkg::CS_RES);
    assign div_start = cmd.start && (cmd.op == cds_pkg::CS_OMEGA || cmd.op == cds_pkg::CS_FAC);
    assign div_num   = (cmd.op == cds_pkg::CS_FAC) ? cds_pkg::NUM_FAC : cds_pkg::NUM_OMEGA;
    assign div_den   = (cmd.op == cds_pkg::CS_FAC) ? den_reg : {7'b0, st_reg};

    cds_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    cds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // stored velocity is state and survives between beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vel_reg <= '0;
        end else if (cmd.finish && !short_reg) begin
            vel_reg <= ovs ? 32'sd0 : cds_pkg::sat32(nv_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            cur_reg   <= current_pos;
            goal_reg  <= goal_pos;
            dt_reg    <= time_step;
            short_reg <= (time_step < cds_pkg::MIN_DT);
            st_reg    <= (smooth_time < cds_pkg::MIN_ST) ? cds_pkg::MIN_ST : smooth_time;
        end
        if (div_done) begin
            unique case (cmd.op)
                cds_pkg::CS_OMEGA: omega_reg <= div_quo[30:0];
                cds_pkg::CS_FAC:   fac_reg   <= div_quo[16:0];
                default: ;
            endcase
        end
        if (mul_done) begin
            unique case (cmd.op)
                cds_pkg::CS_X:    x_reg    <= (mul_p > cds_pkg::X_LIM_V)
                                            ? cds_pkg::X_LIMIT : mul_p[23:0];
                cds_pkg::CS_X2:   x2_reg   <= mul_p;
                cds_pkg::CS_X3:   x3_reg   <= mul_p;
                cds_pkg::CS_C48:  t48_reg  <= mul_p;
                cds_pkg::CS_C235: t235_reg <= mul_p;
                cds_pkg::CS_MAXC: maxc_reg <= mul_p;
                cds_pkg::CS_OC:   t_reg    <= mul_p;
                cds_pkg::CS_TEMP: temp_reg <= mul_p;
                cds_pkg::CS_OT:   t_reg    <= mul_p;
                cds_pkg::CS_NV:   nv_reg   <= mul_p;
                cds_pkg::CS_RES:  res_reg  <= cds_pkg::isat(res_sum);
                default: ;
            endcase
        end
        if (cmd.start) begin
            unique case (cmd.op)
                cds_pkg::CS_DEN: den_reg <= cds_pkg::ONE_Q + {14'b0, x_reg}
                                          + t48_reg[37:0] + t235_reg[37:0];
                cds_pkg::CS_CLAMP:
                begin
                    if (diff > maxc_reg) begin
                        change_reg <= maxc_reg;
                    end else if (diff < -maxc_reg) begin
                        change_reg <= -maxc_reg;
                    end else begin
                        change_reg <= diff;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.finish) begin
            if (short_reg) begin
                new_pos_reg <= cur_reg;
                new_vel_reg <= vel_reg;
            end else begin
                new_pos_reg <= ovs ? goal_reg : cds_pkg::sat32(res_reg);
                new_vel_reg <= ovs ? 32'sd0 : cds_pkg::sat32(nv_reg);
            end
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.short_in = (time_step < cds_pkg::MIN_DT);
    assign new_pos      = new_pos_reg;
    assign new_velocity = new_vel_reg;

endmodule

[rtl/core/cds_ctrl.sv]
// smoother sequencer: steps the datapath through one update and owns the handshakes
// depends on cds_pkg
`timescale 1ns / 1ps

module cds_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  cds_pkg::sts_t sts,
    output cds_pkg::cmd_t cmd
);

    cds_pkg::ctl_state_t state_reg, state_next;
    logic first_reg, first_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cds_pkg::CS_IDLE:
            begin
                if (in_valid) begin
                    state_next = sts.short_in ? cds_pkg::CS_FIN : cds_pkg::CS_OMEGA;
                end
            end
            cds_pkg::CS_OMEGA: if (sts.div_done) state_next = cds_pkg::CS_X;
            cds_pkg::CS_X:     if (sts.mul_done) state_next = cds_pkg::CS_X2;
            cds_pkg::CS_X2:    if (sts.mul_done) state_next = cds_pkg::CS_X3;
            cds_pkg::CS_X3:    if (sts.mul_done) state_next = cds_pkg::CS_C48;
            cds_pkg::CS_C48:   if (sts.mul_done) state_next = cds_pkg::CS_C235;
            cds_pkg::CS_C235:  if (sts.mul_done) state_next = cds_pkg::CS_DEN;
            cds_pkg::CS_DEN:   state_next = cds_pkg::CS_FAC;
            cds_pkg::CS_FAC:   if (sts.div_done) state_next = cds_pkg::CS_MAXC;
            cds_pkg::CS_MAXC:  if (sts.mul_done) state_next = cds_pkg::CS_CLAMP;
            cds_pkg::CS_CLAMP: state_next = cds_pkg::CS_OC;
            cds_pkg::CS_OC:    if (sts.mul_done) state_next = cds_pkg::CS_TEMP;
            cds_pkg::CS_TEMP:  if (sts.mul_done) state_next = cds_pkg::CS_OT;
            cds_pkg::CS_OT:    if (sts.mul_done) state_next = cds_pkg::CS_NV;
            cds_pkg::CS_NV:    if (sts.mul_done) state_next = cds_pkg::CS_RES;
            cds_pkg::CS_RES:   if (sts.mul_done) state_next = cds_pkg::CS_FIN;
            cds_pkg::CS_FIN:   if (out_free) state_next = cds_pkg::CS_IDLE;
            default:           state_next = cds_pkg::CS_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op     = state_reg;
        cmd.start  = first_reg;
        cmd.load   = (state_reg == cds_pkg::CS_IDLE) && in_valid;
        cmd.finish = (state_reg == cds_pkg::CS_FIN) && out_free;
        in_stall   = (state_reg != cds_pkg::CS_IDLE);
        out_valid  = out_valid_reg;
        // start pulse marks the first cycle of every step
        first_next = (state_next != state_reg);
        out_valid_next = cmd.finish || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= cds_pkg::CS_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[tb/critically_damped_smoother_checker.sv]
// smoother checker: watches both beat channels, predicts each result and compares
// prediction follows the q16.16 smooth-damp arithmetic; depends on the dut's port widths
`timescale 1ns / 1ps

module critically_damped_smoother_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] current_pos,
    input  logic signed [31:0] goal_pos,
    input  logic [30:0]        time_step,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] new_pos,
    input  logic signed [31:0] new_velocity,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);

    localparam longint SAT48 = 64'sd281474976710656;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } smooth_out_t;

    smooth_out_t expected_q[$];
    logic [30:0] smooth_t;
    logic [30:0] speed_limit;
    logic signed [31:0] vel_state;

    function automatic longint clamp48(input longint v);
        if (v > SAT48) return SAT48;
        if (v < -SAT48) return -SAT48;
        return v;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // q16.16 product, truncated toward zero, saturated
    function automatic longint qmul(input longint a, input longint b);
        logic neg;
        logic [127:0] p;
        logic [63:0] ma;
        logic [63:0] mb;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = ma * mb;
        p = p >> 16;
        if (p > SAT48) p = SAT48;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic smooth_out_t predict_step(input logic signed [31:0] cur_in,
                                                 input logic signed [31:0] goal_in,
                                                 input logic [30:0] dt_in);
        smooth_out_t r;
        longint cur, goal, dt, st, omega, x, x2, x3, den, fac;
        longint change, maxc, tgt, temp, nv, res;
        cur = cur_in;
        goal = goal_in;
        dt = dt_in;
        if (dt < 66) begin
            r.pos = cur_in;
            r.vel = vel_state;
            return r;
        end
        st = smooth_t;
        if (st < 7) st = 7;
        omega = (64'sd1 <<< 33) / st;
        x = qmul(omega, dt);
        if (x > 8388608) x = 8388608;
        x2 = qmul(x, x);
        x3 = qmul(x2, x);
        den = 65536 + x + qmul(31457, x2) + qmul(15401, x3);
        fac = (64'sd1 <<< 32) / den;
        change = cur - goal;
        maxc = qmul(longint'(speed_limit), st);
        if (change > maxc) change = maxc;
        if (change < -maxc) change = -maxc;
        tgt = cur - change;
        temp = qmul(clamp48(longint'(vel_state) + qmul(omega, change)), dt);
        nv = qmul(clamp48(longint'(vel_state) - qmul(omega, temp)), fac);
        res = clamp48(tgt + qmul(clamp48(change + temp), fac));
        // overshoot snaps to the goal
        if ((goal - cur > 0) == (res > goal)) begin
            res = goal;
            nv = 0;
        end
        vel_state = clamp32(nv);
        r.pos = clamp32(res);
        r.vel = vel_state;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        smooth_out_t got;
        smooth_out_t want;
        if (!rst_n)
        begin
            smooth_t = 31'd65536;
            speed_limit = 31'h7FFF_FFFF;
            vel_state = '0;
            expected_q.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == 3'd0) smooth_t = pwdata[30:0];
                else if (paddr == 3'd4) speed_limit = pwdata[30:0];
            end
            if (in_valid && !in_stall)
                expected_q.push_back(predict_step(current_pos, goal_pos, time_step));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got.pos = new_pos;
                got.vel = new_velocity;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat pos=%0d vel=%0d", new_pos, new_velocity);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: pos exp %0d got %0d, vel exp %0d got %0d",
                                     want.pos, got.pos, want.vel, got.vel);
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

[tb/critically_damped_smoother_unit_tb.sv]
// smoother testbench top: clock, reset, register writes, beat stimulus and verdict
// depends on critically_damped_smoother_unit and critically_damped_smoother_checker
`timescale 1ns / 1ps

module critically_damped_smoother_unit_tb;

    localparam logic [2:0] ADDR_SMOOTH_TIME = 3'd0;
    localparam logic [2:0] ADDR_MAX_SPEED   = 3'd4;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] current_pos;
    logic signed [31:0] goal_pos;
    logic [30:0] time_step;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] new_pos;
    logic signed [31:0] new_velocity;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    int fail_count;
    int pending;
    int results_seen;
    int beats_sent;
    bit hold_long;

    critically_damped_smoother_unit dut (.*);

    critically_damped_smoother_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall per beat, one long hold-off on request
    initial
    begin
        int wait_cycles;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                out_stall = 1'b1;
                repeat (1500) @(negedge clk);
                hold_long = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            out_stall = 1'b1;
            repeat (wait_cycles) @(negedge clk);
            out_stall = 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_beat(input logic signed [31:0] cur, input logic signed [31:0] goal,
                             input logic [30:0] dt, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if (gaps && $urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        current_pos = cur;
        goal_pos = goal;
        time_step = dt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [30:0] rand_dt();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 70));
            1: return 31'($urandom_range(66, 6554));
            2: return 31'($urandom_range(66, 65536));
            3: return 31'($urandom_range(0, 300000));
            4: return 31'($urandom());
            default: return 31'($urandom_range(600, 2200));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 2000000)) - 1000000;
            2: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // a smoothing run: goal held but for random jumps, position stepped an eighth toward it or drawn at random
    task automatic random_phase(input int count);
        logic signed [31:0] goal;
        logic signed [31:0] cur;
        int i;
        goal = rand_pos();
        cur = rand_pos();
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                goal = rand_pos();
                cur = rand_pos();
            end
            else if ($urandom_range(0, 2) != 0)
                cur = cur + (goal - cur) / 8;
            else
                cur = rand_pos();
            send_beat(cur, goal, rand_dt(), 1'b1);
        end
    endtask

    initial
    begin
        logic [31:0] st_vals [5];
        logic [31:0] ms_vals [5];
        int p;
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        current_pos = '0;
        goal_pos = '0;
        time_step = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        beats_sent = 0;
        hold_long = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed beats at reset settings
        send_beat(32'sh0, 32'sh10000, 31'd0, 1'b0);
        send_beat(32'sh0, 32'sh10000, 31'd65, 1'b0);
        send_beat(32'sh0, 32'sh10000, 31'd66, 1'b0);
        send_beat(32'sh0, 32'sh10000, 31'd6554, 1'b0);
        send_beat(32'sh10000, 32'sh0, 31'd6554, 1'b0);
        send_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 31'd6554, 1'b0);
        send_beat(32'sh7FFF_FFFF, 32'sh8000_0000, 31'd65536, 1'b0);
        send_beat(32'sh5, 32'sh5, 31'd1000, 1'b0);
        send_beat(32'sh0, 32'sh10000, 31'h7FFF_FFFF, 1'b0);
        send_beat(32'shFFFF_0000, 32'sh0, 31'd40, 1'b0);
        send_beat(32'sh1234_5678, 32'shEDCB_A988, 31'h5555_5555, 1'b0);
        send_beat(32'sh0, 32'sh1, 31'h2AAA_AAAA, 1'b0);
        drain();

        // tiny smoothing time and zero speed limit
        write_reg(ADDR_SMOOTH_TIME, 32'd0);
        write_reg(ADDR_MAX_SPEED, 32'd0);
        send_beat(32'sh0, 32'sh40000, 31'd6554, 1'b0);
        send_beat(32'sh0, 32'shFFFC_0000, 31'd66, 1'b0);
        drain();
        write_reg(ADDR_SMOOTH_TIME, 32'd6);
        write_reg(ADDR_MAX_SPEED, 32'd65536);
        send_beat(32'sh0, 32'sh40000, 31'd100, 1'b0);
        send_beat(32'sh40000, 32'sh0, 31'd100, 1'b0);
        drain();
        write_reg(ADDR_SMOOTH_TIME, 32'hFFFF_FFFF);
        write_reg(ADDR_MAX_SPEED, 32'hFFFF_FFFF);
        send_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 31'd65536, 1'b0);
        send_beat(32'sh0, 32'sh10000, 31'h7FFF_FFFF, 1'b0);
        drain();

        st_vals = '{32'd65536, 32'd7, 32'd19661, 32'h7FFF_FFFF, 32'd300000};
        ms_vals = '{32'h7FFF_FFFF, 32'd0, 32'd655360, 32'd1000, 32'd65536};
        for (p = 0; p < 10; p++)
        begin
            if (p < 5)
            begin
                write_reg(ADDR_SMOOTH_TIME, st_vals[p]);
                write_reg(ADDR_MAX_SPEED, ms_vals[p]);
            end
            else
            begin
                write_reg(ADDR_SMOOTH_TIME, $urandom_range(0, 1) ? $urandom() :
                          $urandom_range(0, 200000));
                write_reg(ADDR_MAX_SPEED, $urandom_range(0, 1) ? $urandom() :
                          $urandom_range(0, 2000000));
            end
            if (p == 2) hold_long = 1'b1;
            random_phase(190);
            // sender waits for every result before going on
            drain();
        end

        $display("run covered %0d beats sent and %0d results over ten register settings",
                 beats_sent, results_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
